// File: hw/rtl/bfo_pkg.sv
`default_nettype none
package bfo_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int EXP_W      = 64;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 5;
  localparam int STAT_W     = 2;
  localparam int OCC_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = CFG_IDX_W'(1);

  localparam logic [STAT_W-1:0] ST_OK    = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_EMPTY = STAT_W'(2);

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [2:0] {
    OP_ENQ,
    OP_OVW,
    OP_REFUSE,
    OP_DEQ,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    logic load;
    logic commit;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic empty;
    logic ovw_en;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/bfo_in_if.sv
`default_nettype none
interface bfo_in_if;
  import bfo_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [DATA_WIDTH-1:0] data_in;
  logic [EXP_W-1:0]      expiry_in;

  modport source (output valid, output kind, output data_in, output expiry_in, input ready);
  modport sink   (input valid, input kind, input data_in, input expiry_in, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bfo_out_if.sv
`default_nettype none
interface bfo_out_if;
  import bfo_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [DATA_WIDTH-1:0] data_out;
  logic [EXP_W-1:0]      expiry_out;
  logic                  dropped;
  logic [OCC_W-1:0]      occupancy;

  modport source (output valid, output status, output data_out, output expiry_out,
                  output dropped, output occupancy, input ready);
  modport sink   (input valid, input status, input data_out, input expiry_out,
                  input dropped, input occupancy, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bounded_fifo_with_overwrite_top.sv
`default_nettype none
// Bounded FIFO of (data, 64-bit expiry) entries with optional overwrite of
// the oldest entry when full.
// in_ch:  valid/ready channel carrying kind (0 enqueue, 1 dequeue),
//         data_in and expiry_in. A transfer happens when valid and ready
//         are both high at a rising edge.
// out_ch: one result per item: status, data_out, expiry_out, dropped and
//         the occupancy after the operation.
// cfg_*:  write port; index 0 capacity (0 acts as 1, above 16 as 16),
//         index 1 overwrite enable. Write only while the queue is idle.
// An item taken moves to an execute step, where in_ch.ready is low, and
// commits once the result register is free; the commit fills it and
// raises out_ch.valid. The entry store is read into a register at intake.
// A finished result sits in the output register while the next item is
// taken; if the receiver stalls, that next item waits at its commit step
// and in_ch.ready stays low until the result register frees.
// Reset clears pointers and count, sets capacity 16 and overwrite off; the
// entry store is not cleared, as it is only read after being written.
module bounded_fifo_with_overwrite_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bfo_in_if.sink                              in_ch,
  bfo_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bfo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bfo_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfo_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_ch.kind),
    .in_data       (in_ch.data_in),
    .in_expiry     (in_ch.expiry_in),
    .cmd           (cmd),
    .stat          (stat),
    .res_status    (out_ch.status),
    .res_data      (out_ch.data_out),
    .res_expiry    (out_ch.expiry_out),
    .res_dropped   (out_ch.dropped),
    .res_occupancy (out_ch.occupancy)
  );

endmodule
`default_nettype wire

// File: hw/rtl/bfo_ctrl.sv
`default_nettype none
module bfo_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire bfo_pkg::dp_stat_t stat,
  output bfo_pkg::dp_cmd_t      cmd
);
  import bfo_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   commit;
  op_t    op;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // result register must be free, or emptied this cycle, before committing
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    priority if (stat.kind == KIND_DEQ) begin
      op = stat.empty ? OP_EMPTY : OP_DEQ;
    end else if (stat.full) begin
      op = (stat.ovw_en && !stat.empty) ? OP_OVW : OP_REFUSE;
    end else begin
      op = OP_ENQ;
    end
  end

  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = commit;
  assign cmd.op     = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before commit");
  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");
  a_no_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> !in_ready)
    else $error("commit while idle");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/bfo_dpath.sv
`default_nettype none
module bfo_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [bfo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bfo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                in_kind,
  input  wire logic [bfo_pkg::DATA_WIDTH-1:0]      in_data,
  input  wire logic [bfo_pkg::EXP_W-1:0]           in_expiry,
  input  wire bfo_pkg::dp_cmd_t                    cmd,
  output bfo_pkg::dp_stat_t                        stat,
  output logic [bfo_pkg::STAT_W-1:0]               res_status,
  output logic [bfo_pkg::DATA_WIDTH-1:0]           res_data,
  output logic [bfo_pkg::EXP_W-1:0]                res_expiry,
  output logic                                     res_dropped,
  output logic [bfo_pkg::OCC_W-1:0]                res_occupancy
);
  import bfo_pkg::*;

  logic [DATA_WIDTH-1:0] data_mem [DEPTH];
  logic [EXP_W-1:0]      exp_mem  [DEPTH];

  logic [PTR_W-1:0]      rp_r, wp_r, rp_inc, wp_inc;
  logic [CNT_W-1:0]      cnt_r;
  logic [CAP_W-1:0]      cap_r, cap_eff;
  logic                  ovw_r;
  logic                  kind_r;
  logic [DATA_WIDTH-1:0] din_r, rd_data_r;
  logic [EXP_W-1:0]      ein_r, rd_exp_r;

  logic [STAT_W-1:0]     status_r;
  logic [DATA_WIDTH-1:0] dout_r;
  logic [EXP_W-1:0]      eout_r;
  logic                  dropped_r;
  logic [CNT_W-1:0]      occ_r;
  logic                  mem_we;

  // zero acts as one, anything above the ring size as the ring size
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign rp_inc = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
  assign wp_inc = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);

  assign stat.kind   = kind_r;
  assign stat.full   = (cnt_r >= CNT_W'(cap_eff));
  assign stat.empty  = (cnt_r == '0);
  assign stat.ovw_en = ovw_r;

  assign mem_we = cmd.commit && ((cmd.op == OP_ENQ) || (cmd.op == OP_OVW));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data_r <= data_mem[rp_r];
      rd_exp_r  <= exp_mem[rp_r];
    end
    if (mem_we) begin
      data_mem[wp_r] <= din_r;
      exp_mem[wp_r]  <= ein_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      din_r  <= in_data;
      ein_r  <= in_expiry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      cnt_r <= '0;
      cap_r <= CAP_RESET;
      ovw_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        priority if (cfg_index == REG_CAPACITY) begin
          cap_r <= cfg_data[CAP_W-1:0];
        end else if (cfg_index == REG_OVERWRITE) begin
          ovw_r <= cfg_data[0];
        end
      end
      if (cmd.commit) begin
        unique case (cmd.op)
          OP_ENQ: begin
            wp_r  <= wp_inc;
            cnt_r <= cnt_r + CNT_W'(1);
          end
          OP_OVW: begin
            wp_r <= wp_inc;
            rp_r <= rp_inc;
          end
          OP_DEQ: begin
            rp_r  <= rp_inc;
            cnt_r <= cnt_r - CNT_W'(1);
          end
          OP_REFUSE, OP_EMPTY: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= ST_OK;
      dout_r    <= '0;
      eout_r    <= '0;
      dropped_r <= 1'b0;
      occ_r     <= cnt_r;
      unique case (cmd.op)
        OP_ENQ: occ_r <= cnt_r + CNT_W'(1);
        OP_OVW: begin
          dout_r    <= rd_data_r;
          eout_r    <= rd_exp_r;
          dropped_r <= 1'b1;
        end
        OP_REFUSE: status_r <= ST_FULL;
        OP_DEQ: begin
          dout_r <= rd_data_r;
          eout_r <= rd_exp_r;
          occ_r  <= cnt_r - CNT_W'(1);
        end
        OP_EMPTY: status_r <= ST_EMPTY;
        default: status_r <= ST_OK;
      endcase
    end
  end

  assign res_status    = status_r;
  assign res_data      = dout_r;
  assign res_expiry    = eout_r;
  assign res_dropped   = dropped_r;
  assign res_occupancy = OCC_W'(occ_r);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond ring size");
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cmd.op == OP_ENQ) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("enqueue did not raise count");
  // both pointers step together; count may sit above capacity after a lowering
  a_ovw_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cmd.op == OP_OVW) |=>
      ($stable(cnt_r) && (rp_r == $past(rp_inc)) && (wp_r == $past(wp_inc))))
    else $error("overwrite disturbed count or pointers");
`endif

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import bfo_pkg::*;

  localparam int          SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          REPORT_MAX    = 10;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [DATA_WIDTH-1:0] data;
    logic [EXP_W-1:0]      expiry;
    logic                  dropped;
    logic [OCC_W-1:0]      occupancy;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bfo_in_if  in_ch ();
  bfo_out_if out_ch ();

  bounded_fifo_with_overwrite_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // shadow of the queue
  logic [DATA_WIDTH-1:0] ring_data   [DEPTH];
  logic [EXP_W-1:0]      ring_expiry [DEPTH];
  int                    rd_ptr = 0;
  int                    wr_ptr = 0;
  int                    fill = 0;
  logic [CAP_W-1:0]      cap_reg = CAP_RESET;
  logic                  ovw_reg = 1'b0;

  queue_result_t pending_results[$];
  queue_result_t got, want;
  int            fail_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int unsigned   cycle_count = 0;

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_ENQ;
    in_ch.data_in   = '0;
    in_ch.expiry_in = '0;
    out_ch.ready    = 1'b0;
  end

  function automatic int next_slot(input int p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic queue_result_t predict_queue_op(input logic kind,
                                                     input logic [DATA_WIDTH-1:0] d,
                                                     input logic [EXP_W-1:0] e);
    queue_result_t r;
    int            limit;
    r = '0;
    limit = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    if (kind == KIND_ENQ) begin
      if (fill >= limit) begin
        if (ovw_reg && fill > 0) begin
          r.data    = ring_data[rd_ptr];
          r.expiry  = ring_expiry[rd_ptr];
          r.dropped = 1'b1;
          rd_ptr = next_slot(rd_ptr);
          ring_data[wr_ptr]   = d;
          ring_expiry[wr_ptr] = e;
          wr_ptr = next_slot(wr_ptr);
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        ring_data[wr_ptr]   = d;
        ring_expiry[wr_ptr] = e;
        wr_ptr = next_slot(wr_ptr);
        fill++;
      end
    end else begin
      if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data   = ring_data[rd_ptr];
        r.expiry = ring_expiry[rd_ptr];
        rd_ptr = next_slot(rd_ptr);
        fill--;
      end
    end
    r.occupancy = OCC_W'(fill);
    return r;
  endfunction

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // predict on each input transfer, then check each output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(predict_queue_op(in_ch.kind, in_ch.data_in,
                                                   in_ch.expiry_in));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.data_out, out_ch.expiry_out, out_ch.dropped,
                out_ch.occupancy};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: result with nothing expected: st=%0d d=%h e=%h drop=%b occ=%0d",
                     $realtime, got.status, got.data, got.expiry, got.dropped,
                     got.occupancy);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.data !== want.data ||
              got.expiry !== want.expiry || got.dropped !== want.dropped ||
              got.occupancy !== want.occupancy) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("%0t: mismatch exp st=%0d d=%h e=%h drop=%b occ=%0d",
                       $realtime, want.status, want.data, want.expiry, want.dropped,
                       want.occupancy);
              $display("%0t:          got st=%0d d=%h e=%h drop=%b occ=%0d",
                       $realtime, got.status, got.data, got.expiry, got.dropped,
                       got.occupancy);
            end
          end
        end
      end
    end
  end

  task automatic send_item(input logic kind, input logic [DATA_WIDTH-1:0] d,
                           input logic [EXP_W-1:0] e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.data_in   <= d;
    in_ch.expiry_in <= e;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
  endtask

  // hold the sender off until every expected result is in and the block is quiet
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) cap_reg = val;
    else ovw_reg = val[0];
  endtask

  function automatic logic [DATA_WIDTH-1:0] rand_word();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return DATA_WIDTH'($urandom);
  endfunction

  function automatic logic [EXP_W-1:0] rand_stamp();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // ordering, empty dequeue and field extremes at reset settings
  task automatic test_basic_order();
    send_item(KIND_DEQ, '1, '1);
    send_item(KIND_ENQ, '0, '0);
    send_item(KIND_ENQ, '1, '1);
    send_item(KIND_DEQ, '0, '0);
    send_item(KIND_DEQ, '0, '0);
    send_item(KIND_DEQ, '0, '0);
  endtask

  // refusal when full, including capacity dropped below the count
  task automatic test_refuse_full();
    write_reg(REG_CAPACITY, CFG_DATA_W'(2));
    write_reg(REG_OVERWRITE, CFG_DATA_W'(0));
    send_item(KIND_ENQ, 32'h0000_0001, 64'h0000_0000_0000_0010);
    send_item(KIND_ENQ, 32'h8000_0000, 64'h8000_0000_0000_0000);
    send_item(KIND_ENQ, 32'hdead_beef, 64'hffff_0000_ffff_0000);
    write_reg(REG_CAPACITY, CFG_DATA_W'(1));
    send_item(KIND_ENQ, 32'h1234_5678, 64'h0123_4567_89ab_cdef);
  endtask

  // overwrite of the oldest; capacity 0 acts as 1, above depth as depth
  task automatic test_overwrite_full();
    write_reg(REG_OVERWRITE, CFG_DATA_W'(1));
    send_item(KIND_ENQ, 32'haaaa_5555, 64'h5555_aaaa_5555_aaaa);
    write_reg(REG_CAPACITY, CFG_DATA_W'(0));
    send_item(KIND_ENQ, '1, '1);
    write_reg(REG_CAPACITY, CFG_DATA_W'(31));
    send_item(KIND_ENQ, 32'h0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0);
    send_item(KIND_DEQ, '0, '0);
    send_item(KIND_DEQ, '0, '0);
    send_item(KIND_DEQ, '0, '0);
    send_item(KIND_DEQ, '0, '0);
  endtask

  task automatic run_phase(input int n_items, input int enq_pct);
    repeat (n_items) begin
      send_item(($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ, rand_word(),
                rand_stamp());
      if ($urandom_range(99) < 3) wait_idle();
    end
  endtask

  task automatic test_random_traffic();
    int caps[10] = '{0, 1, 2, 3, 5, 8, 15, 16, 17, 31};
    int enq_pct;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 70 : 0;
      recv_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 8 : 0;
      for (int ph = 0; ph < 8; ph++) begin
        enq_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 30 : 55;
        write_reg(REG_CAPACITY, (ph == 7) ? CFG_DATA_W'($urandom_range(31))
                                          : CFG_DATA_W'(caps[(mode * 8 + ph) % 10]));
        write_reg(REG_OVERWRITE, CFG_DATA_W'(ph % 2));
        run_phase(27, enq_pct);
      end
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    send_idle_pct = 8;
    recv_idle_pct = 70;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_order();
    test_refuse_full();
    test_overwrite_full();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bfo_pkg.sv
hw/rtl/bfo_in_if.sv
hw/rtl/bfo_out_if.sv
hw/rtl/bfo_ctrl.sv
hw/rtl/bfo_dpath.sv
hw/rtl/bounded_fifo_with_overwrite_top.sv
bench/tb.sv
